// ===== hdl/sha1_message_digest_defines.svh =====
// ----------------------------------------------------------------------------
// sha1 digest assertion macros
// shared property wrappers for the sha1 digest block
// ----------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_DEFINES_SVH

// implication checked on every clock edge outside reset
`define SHA1_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha1 check failed");

// implication whose consequent is checked in the cycle after the antecedent
`define SHA1_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha1 check failed");

`endif

// ===== hdl/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1 package
// shared types, constants and helpers of the sha1 digest block
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned CountW  = 61;
  localparam int unsigned RoundW  = 7;
  localparam int unsigned NumRounds = 80;

  localparam logic [WordW-1:0] H0 = 32'h67452301;
  localparam logic [WordW-1:0] H1 = 32'hefcdab89;
  localparam logic [WordW-1:0] H2 = 32'h98badcfe;
  localparam logic [WordW-1:0] H3 = 32'h10325476;
  localparam logic [WordW-1:0] H4 = 32'hc3d2e1f0;
  localparam logic [7:0]       PadByte = 8'h80;

  typedef enum logic [0:0] {
    CMD_ABSORB = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ABSORB,
    ST_FINISH,
    ST_PAD,
    ST_ROUNDS,
    ST_FOLD,
    ST_LEN,
    ST_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic       write_byte;   // place byte at current position
    logic       write_pad;    // place 0x80 and clear tail words
    logic       clear_block;  // zero the whole buffer
    logic       write_len;    // put bit length in words 14 and 15
    logic       load_work;    // a..e from chain words
    logic       round;        // one compression round
    logic       fold;         // add working vars into chain words
    logic       reset_msg;    // chain words and count back to initial
    logic       inc_count;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic       block_full;   // position is 63
    logic       pad_overflow; // position is 56 or more
    logic       last_round;
  } stat_t;

  function automatic logic [WordW-1:0] rotl1(input logic [WordW-1:0] x);
    return {x[WordW-2:0], x[WordW-1]};
  endfunction

  function automatic logic [WordW-1:0] round_k(input logic [RoundW-1:0] t);
    logic [WordW-1:0] k;
    if (t < 7'd20)      k = 32'h5a827999;
    else if (t < 7'd40) k = 32'h6ed9eba1;
    else if (t < 7'd60) k = 32'h8f1bbcdc;
    else                k = 32'hca62c1d6;
    return k;
  endfunction

  function automatic logic [WordW-1:0] round_f(input logic [RoundW-1:0] t,
                                               input logic [WordW-1:0] b,
                                               input logic [WordW-1:0] c,
                                               input logic [WordW-1:0] d);
    logic [WordW-1:0] f;
    if (t < 7'd20)      f = (b & c) | (~b & d);
    else if (t < 7'd40) f = b ^ c ^ d;
    else if (t < 7'd60) f = (b & c) | (b & d) | (c & d);
    else                f = b ^ c ^ d;
    return f;
  endfunction

endpackage

// ===== hdl/sha1_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha1 controller
// sequences absorb, padding, compression rounds and digest output
// ----------------------------------------------------------------------------
module sha1_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_cmd_i,
  output logic            in_ready_o,
  input  sha1_pkg::stat_t stat_i,
  output sha1_pkg::ctrl_t ctrl_o,
  output logic            emit_o,      // output register loading digest
  input  logic            emit_done_i, // all five words gone
  output logic            busy_o
);
  import sha1_pkg::*;

  state_e state_q, state_d;
  logic   final_q, final_d; // compressing a block that carries the length
  logic   over_q, over_d;   // second padding block still to do

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      final_q <= 1'b0;
      over_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      final_q <= final_d;
      over_q  <= over_d;
    end
  end

  always_comb begin
    state_d = state_q;
    final_d = final_q;
    over_d  = over_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_cmd_i == CMD_FINISH) state_d = ST_PAD;
          else                        state_d = ST_ABSORB;
        end
      end
      ST_ABSORB: begin
        if (stat_i.block_full) begin
          final_d = 1'b0;
          state_d = ST_ROUNDS;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PAD: begin
        if (stat_i.pad_overflow) begin
          over_d  = 1'b1;
          final_d = 1'b0;
          state_d = ST_ROUNDS;
        end else begin
          over_d  = 1'b0;
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        final_d = 1'b1;
        state_d = ST_ROUNDS;
      end
      ST_ROUNDS: begin
        if (stat_i.last_round) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        if (final_q)     state_d = ST_EMIT;
        else if (over_q) state_d = ST_FINISH;
        else             state_d = ST_IDLE;
      end
      ST_FINISH: begin
        over_d  = 1'b0;
        state_d = ST_LEN;
      end
      ST_EMIT: begin
        if (emit_done_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    emit_o     = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_ABSORB: begin
        ctrl_o.write_byte = 1'b1;
        ctrl_o.inc_count  = 1'b1;
        ctrl_o.load_work  = stat_i.block_full;
      end
      ST_PAD: begin
        ctrl_o.write_pad = 1'b1;
        ctrl_o.load_work = stat_i.pad_overflow;
      end
      ST_FINISH: ctrl_o.clear_block = 1'b1;
      ST_LEN: begin
        ctrl_o.write_len = 1'b1;
        ctrl_o.load_work = 1'b1;
      end
      ST_ROUNDS: ctrl_o.round = 1'b1;
      ST_FOLD: begin
        ctrl_o.fold = 1'b1;
        emit_o      = final_q;
      end
      ST_EMIT: ctrl_o.reset_msg = emit_done_i;
      default: ;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ===== hdl/sha1_datapath.sv =====
// ----------------------------------------------------------------------------
// sha1 datapath
// block buffer, schedule window, working variables and chain words
// ----------------------------------------------------------------------------
module sha1_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_take_i,  // input transfer
  input  logic [7:0]                in_byte_i,
  input  sha1_pkg::ctrl_t           ctrl_i,
  output sha1_pkg::stat_t           stat_o,
  output logic [5*sha1_pkg::WordW-1:0] chain_o
);
  import sha1_pkg::*;

  logic [WordW-1:0]  w_q [16];
  logic [WordW-1:0]  h_q [5];
  logic [WordW-1:0]  a_q, b_q, c_q, d_q, e_q;
  logic [CountW-1:0] count_q;
  logic [RoundW-1:0] t_q;
  logic [7:0]        byte_q;
  logic [5:0]        pos;
  logic [3:0]        word;
  logic [4:0]        sh;
  logic [WordW-1:0]  wt, wnew, tmp;
  logic [CountW+2:0] bits;

  assign pos  = count_q[5:0];
  assign word = pos[5:2];
  assign sh   = {~pos[1:0], 3'b000};
  assign bits = {count_q, 3'b000};

  // schedule window shifts: w_q[0] is the current word
  assign wnew = rotl1(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]);
  assign wt   = w_q[0];
  assign tmp  = {a_q[26:0], a_q[31:27]} + round_f(t_q, b_q, c_q, d_q) + e_q + wt
                + round_k(t_q);

  assign stat_o.block_full   = (pos == 6'd63);
  assign stat_o.pad_overflow = (pos >= 6'd56);
  assign stat_o.last_round   = (t_q == RoundW'(NumRounds - 1));

  always_ff @(posedge clk_i) begin
    if (in_take_i) byte_q <= in_byte_i;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.write_byte) begin
      if (pos[1:0] == 2'd0) w_q[word] <= WordW'(byte_q) << sh;
      else                  w_q[word] <= w_q[word] | (WordW'(byte_q) << sh);
    end else if (ctrl_i.write_pad) begin
      for (int i = 0; i < 16; i++) begin
        if (4'(i) == word) begin
          if (pos[1:0] == 2'd0) w_q[i] <= WordW'(PadByte) << sh;
          else w_q[i] <= (w_q[i] & ~(32'hffffffff >> (6'd32 - 6'(sh) - 6'd8) >> 0
                          & ~(32'hffffffff << (6'(sh) + 6'd8)) | 32'h0)
                          & (32'hffffffff << (6'(sh) + 6'd8)))
                         | (WordW'(PadByte) << sh);
        end else if (4'(i) > word) begin
          w_q[i] <= '0;
        end
      end
    end else if (ctrl_i.clear_block) begin
      for (int i = 0; i < 16; i++) w_q[i] <= '0;
    end else if (ctrl_i.write_len) begin
      w_q[14] <= bits[63:32];
      w_q[15] <= bits[31:0];
    end else if (ctrl_i.round) begin
      // the window holds w[t..t+15], so w[t+16] enters at the top every round
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_work) begin
      a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
    end else if (ctrl_i.round) begin
      a_q <= tmp;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
      count_q <= '0;
      t_q     <= '0;
    end else begin
      if (ctrl_i.reset_msg) begin
        h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
        count_q <= '0;
      end else if (ctrl_i.fold) begin
        h_q[0] <= h_q[0] + a_q;
        h_q[1] <= h_q[1] + b_q;
        h_q[2] <= h_q[2] + c_q;
        h_q[3] <= h_q[3] + d_q;
        h_q[4] <= h_q[4] + e_q;
      end
      if (ctrl_i.inc_count) count_q <= count_q + 1'b1;
      if (ctrl_i.load_work)  t_q <= '0;
      else if (ctrl_i.round) t_q <= t_q + 1'b1;
    end
  end

  assign chain_o = {h_q[4] + e_q, h_q[3] + d_q, h_q[2] + c_q, h_q[1] + b_q,
                    h_q[0] + a_q};

endmodule

// ===== hdl/sha1_out.sv =====
// ----------------------------------------------------------------------------
// sha1 output stage
// holds the digest and hands out its five words one transfer at a time
// ----------------------------------------------------------------------------
module sha1_out (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic [5*sha1_pkg::WordW-1:0] digest_i,
  input  logic                         tready_i,
  output logic                         tvalid_o,
  output logic [39:0]                  tdata_o,
  output logic                         tlast_o,
  output logic                         done_o
);
  import sha1_pkg::*;

  logic [5*WordW-1:0] dig_q;
  logic [2:0]         idx_q;
  logic               valid_q;
  logic               fire;

  assign fire = valid_q && tready_i;

  always_ff @(posedge clk_i) begin
    if (load_i) dig_q <= digest_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (fire) begin
      if (idx_q == 3'd4) valid_q <= 1'b0;
      idx_q <= idx_q + 1'b1;
    end
  end

  assign tvalid_o = valid_q;
  assign tlast_o  = (idx_q == 3'd4);
  assign tdata_o  = {5'b0, idx_q, dig_q[32*idx_q +: 32]};
  assign done_o   = fire && (idx_q == 3'd4);

endmodule

// ===== hdl/sha1_message_digest.sv =====
// ----------------------------------------------------------------------------
// sha1 message digest
// sha1 over a byte stream: absorb bytes, finish to emit the 160-bit digest
// ----------------------------------------------------------------------------
// an absorb byte is stored in the block buffer; a byte completing a 64-byte block
// then runs load, rounds (one per cycle on the single round unit) and fold, and the
// next byte is taken only in idle; finish pads, compresses (twice with a second
// padding block) and folds, then five words leave one per cycle if ready
// reset (async, active low) loads the initial chain words and clears the count
module sha1_message_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte[7:0]
  input  logic        s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // digest_word[31:0], word_index[34:32], zero fill
  output logic        m_axis_tlast   // last
);
  import sha1_pkg::*;
  `include "sha1_message_digest_defines.svh"

  ctrl_t               ctrl;
  stat_t               stat;
  logic                emit, emit_done, busy, take;
  logic [5*WordW-1:0]  chain;

  assign take = s_axis_tvalid && s_axis_tready;

  sha1_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_cmd_i    (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .stat_i      (stat),
    .ctrl_o      (ctrl),
    .emit_o      (emit),
    .emit_done_i (emit_done),
    .busy_o      (busy)
  );

  sha1_datapath u_dp (
    .clk_i, .rst_ni,
    .in_take_i (take),
    .in_byte_i (s_axis_tdata),
    .ctrl_i    (ctrl),
    .stat_o    (stat),
    .chain_o   (chain)
  );

  sha1_out u_out (
    .clk_i, .rst_ni,
    .load_i   (emit),
    .digest_i (chain),
    .tready_i (m_axis_tready),
    .tvalid_o (m_axis_tvalid),
    .tdata_o  (m_axis_tdata),
    .tlast_o  (m_axis_tlast),
    .done_o   (emit_done)
  );

  `SHA1_ASSERT_IMP(a_no_take_busy, clk_i, rst_ni, busy, !s_axis_tready)
  `SHA1_ASSERT_IMP(a_out_only_busy, clk_i, rst_ni, m_axis_tvalid, busy)
  `SHA1_ASSERT_IMP(a_last_idx, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast,
    m_axis_tdata[34:32] == 3'd4)
  `SHA1_ASSERT_NEXT(a_take_busy, clk_i, rst_ni, take, busy)

endmodule
